// ===== sv/arx_pkg.sv =====
// shared types, constants and helper functions for the arx plant model
package arx_pkg;

	localparam int DATA_W = 16;
	localparam int COEF_W = 16;
	localparam int PACK_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int DLEN_W = 7;
	localparam int CLAMP_EN_W = 2;
	localparam int FRAC_SHIFT = 12;

	localparam int NUM_A_TAPS_DEF = 3;
	localparam int NUM_B_TAPS_DEF = 3;
	localparam int MAX_DELAY_DEF = 64;

	localparam logic signed [DATA_W-1:0] LIMIT_HI = 16'sd25600;
	localparam logic signed [DATA_W-1:0] LIMIT_LO = -16'sd25600;
	localparam logic signed [DATA_W-1:0] Q88_MAX = 16'sh7fff;
	localparam logic signed [DATA_W-1:0] Q88_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		OP_SIMULATE = 2'd0,
		OP_LOAD     = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_COEF    = 3'd0,
		CFG_B_COEF    = 3'd1,
		CFG_CTRL_MIN  = 3'd2,
		CFG_CTRL_MAX  = 3'd3,
		CFG_OUT_MIN   = 3'd4,
		CFG_OUT_MAX   = 3'd5,
		CFG_DELAY_LEN = 3'd6,
		CFG_CLAMP_EN  = 3'd7
	} cfg_idx_t;

	// saturate one raw limit to the legal limit range
	function automatic logic signed [DATA_W-1:0] limit_sat(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		r = v;
		if (v < LIMIT_LO) begin
			r = LIMIT_LO;
		end else if (v > LIMIT_HI) begin
			r = LIMIT_HI;
		end
		return r;
	endfunction

	// clamp with limits sanitized first; swapped limits are reordered
	function automatic logic signed [DATA_W-1:0] clamp_pair(
		input logic signed [DATA_W-1:0] v,
		input logic signed [DATA_W-1:0] lo_raw,
		input logic signed [DATA_W-1:0] hi_raw
	);
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		logic signed [DATA_W-1:0] lo_s;
		logic signed [DATA_W-1:0] hi_s;
		logic signed [DATA_W-1:0] r;
		lo = limit_sat(lo_raw);
		hi = limit_sat(hi_raw);
		lo_s = (lo > hi) ? hi : lo;
		hi_s = (lo > hi) ? lo : hi;
		r = v;
		if (v < lo_s) begin
			r = lo_s;
		end else if (v > hi_s) begin
			r = hi_s;
		end
		return r;
	endfunction

	// one Q3.12 tap out of a packed coefficient word; taps past the third read zero
	function automatic logic signed [COEF_W-1:0] coef_tap(
		input logic [PACK_W-1:0] packed_coef,
		input logic [1:0]        idx
	);
		logic signed [COEF_W-1:0] r;
		case (idx)
			2'd0: r = packed_coef[15:0];
			2'd1: r = packed_coef[31:16];
			2'd2: r = packed_coef[47:32];
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/arx_model_step.sv =====
// arx plant model with transport delay: delay line, histories and output stage
//
// Usage:
//  Input channel (in_valid / in_stall) carries op, control_sample and
//  measured_output; a transfer happens on a clock edge with in_valid high and
//  in_stall low. Simulate produces one model_output transfer on the output
//  channel (out_valid / out_stall); load history, clear and the unused op code
//  produce nothing.
//  Configuration is written through cfg_we / cfg_index / cfg_data while the
//  block is idle; register i of the list has index i.
//  Pipeline: the delay line is read on the accepting edge into stage 1; when
//  stage 1 advances, the multiply-accumulate updates the histories and loads
//  the output register, which raises out_valid.
//  Throughput: one item per cycle while the output channel does not stall, as
//  the new output feeds back into the output history.
//  Stall: an unaccepted result stays in the output register; a simulate item
//  waiting in stage 1 then holds, and in_stall goes high while it does.
//  Reset: arst_n clears the histories, the delay line valid bits, the pointer,
//  both pipeline valids and the configuration registers to their defaults.
module arx_model_step #(
	parameter int NUM_A_TAPS = arx_pkg::NUM_A_TAPS_DEF,
	parameter int NUM_B_TAPS = arx_pkg::NUM_B_TAPS_DEF,
	parameter int MAX_DELAY  = arx_pkg::MAX_DELAY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [arx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [arx_pkg::PACK_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        op,
	input  logic signed [arx_pkg::DATA_W-1:0] control_sample,
	input  logic signed [arx_pkg::DATA_W-1:0] measured_output,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [arx_pkg::DATA_W-1:0] model_output
);

	localparam int DW = arx_pkg::DATA_W;
	localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int LEN_W = $clog2(MAX_DELAY + 1);
	localparam int EXT_W = ((LEN_W > arx_pkg::DLEN_W) ? LEN_W : arx_pkg::DLEN_W) + 1;
	localparam int PROD_W = DW + arx_pkg::COEF_W;
	localparam int ACC_W = PROD_W + 4;
	localparam int RND_W = ACC_W - arx_pkg::FRAC_SHIFT;
	localparam logic [EXT_W-1:0] MAX_X = EXT_W'(MAX_DELAY);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_DELAY - 1);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (arx_pkg::FRAC_SHIFT - 1));
	localparam logic signed [RND_W-1:0] Y_MAX = RND_W'(arx_pkg::Q88_MAX);
	localparam logic signed [RND_W-1:0] Y_MIN = RND_W'(arx_pkg::Q88_MIN);

	// configuration registers
	logic [arx_pkg::PACK_W-1:0]     a_coef_q;
	logic [arx_pkg::PACK_W-1:0]     b_coef_q;
	logic signed [DW-1:0]           ctrl_min_q;
	logic signed [DW-1:0]           ctrl_max_q;
	logic signed [DW-1:0]           out_min_q;
	logic signed [DW-1:0]           out_max_q;
	logic [arx_pkg::DLEN_W-1:0]     delay_len_q;
	logic [arx_pkg::CLAMP_EN_W-1:0] clamp_en_q;

	// delay line
	logic signed [DW-1:0] dline [MAX_DELAY];
	logic [MAX_DELAY-1:0] dvld_q;
	logic [PTR_W-1:0]     ptr_q;

	// stage 1
	logic                 valid_s1;
	arx_pkg::op_t         op_s1;
	logic signed [DW-1:0] rd_data_s1;
	logic                 rd_vld_s1;
	logic signed [DW-1:0] ym_s1;

	// histories and output register
	logic signed [DW-1:0] ih_q [NUM_B_TAPS];
	logic signed [DW-1:0] oh_q [NUM_A_TAPS];
	logic                 out_valid_q;
	logic signed [DW-1:0] model_output_q;

	arx_pkg::op_t         in_op;
	logic                 accept;
	logic                 push;
	logic                 adv2;
	logic signed [DW-1:0] u_c;
	logic signed [DW-1:0] ym_c;
	logic [EXT_W-1:0]     len_x;
	logic [EXT_W-1:0]     ptr_x;
	logic [EXT_W-1:0]     rd_x;
	logic [PTR_W-1:0]     rd_idx;

	logic signed [DW-1:0]    ih_new [NUM_B_TAPS];
	logic signed [ACC_W-1:0] acc;
	logic signed [RND_W-1:0] y_rnd;
	logic signed [DW-1:0]    y_sat;
	logic signed [DW-1:0]    y_out;

	assign in_op  = arx_pkg::op_t'(op);
	assign adv2   = valid_s1 && ((op_s1 != arx_pkg::OP_SIMULATE) || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv2;
	assign accept = in_valid && !in_stall;
	assign push   = accept && ((in_op == arx_pkg::OP_SIMULATE) || (in_op == arx_pkg::OP_LOAD));

	assign u_c  = clamp_en_q[0] ? arx_pkg::clamp_pair(control_sample, ctrl_min_q, ctrl_max_q)
	                            : control_sample;
	assign ym_c = clamp_en_q[1] ? arx_pkg::clamp_pair(measured_output, out_min_q, out_max_q)
	                            : measured_output;

	// effective delay length in one to MAX_DELAY, read address behind the pointer
	always_comb begin
		if (delay_len_q == '0) begin
			len_x = EXT_W'(1);
		end else if (EXT_W'(delay_len_q) > MAX_X) begin
			len_x = MAX_X;
		end else begin
			len_x = EXT_W'(delay_len_q);
		end
		ptr_x = EXT_W'(ptr_q);
		rd_x  = (ptr_x >= len_x) ? (ptr_x - len_x) : (ptr_x + MAX_X - len_x);
		rd_idx = rd_x[PTR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_coef_q    <= '0;
			b_coef_q    <= '0;
			ctrl_min_q  <= arx_pkg::LIMIT_LO;
			ctrl_max_q  <= arx_pkg::LIMIT_HI;
			out_min_q   <= arx_pkg::LIMIT_LO;
			out_max_q   <= arx_pkg::LIMIT_HI;
			delay_len_q <= arx_pkg::DLEN_W'(1);
			clamp_en_q  <= '0;
		end else if (cfg_we) begin
			case (arx_pkg::cfg_idx_t'(cfg_index))
				arx_pkg::CFG_A_COEF:    a_coef_q    <= cfg_data;
				arx_pkg::CFG_B_COEF:    b_coef_q    <= cfg_data;
				arx_pkg::CFG_CTRL_MIN:  ctrl_min_q  <= cfg_data[DW-1:0];
				arx_pkg::CFG_CTRL_MAX:  ctrl_max_q  <= cfg_data[DW-1:0];
				arx_pkg::CFG_OUT_MIN:   out_min_q   <= cfg_data[DW-1:0];
				arx_pkg::CFG_OUT_MAX:   out_max_q   <= cfg_data[DW-1:0];
				arx_pkg::CFG_DELAY_LEN: delay_len_q <= cfg_data[arx_pkg::DLEN_W-1:0];
				arx_pkg::CFG_CLAMP_EN:  clamp_en_q  <= cfg_data[arx_pkg::CLAMP_EN_W-1:0];
				default: ;
			endcase
		end
	end

	// delay line storage: read before write, so a full-length delay sees the old entry
	always_ff @(posedge clk) begin
		if (push) begin
			dline[ptr_q] <= u_c;
		end
		if (accept) begin
			rd_data_s1 <= dline[rd_idx];
			op_s1      <= in_op;
			ym_s1      <= ym_c;
		end
	end

	// front control: pointer, entry valid bits, stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_q    <= '0;
			ptr_q     <= '0;
			valid_s1  <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				rd_vld_s1 <= dvld_q[rd_idx];
				valid_s1  <= (in_op != arx_pkg::OP_NONE);
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (accept && (in_op == arx_pkg::OP_CLEAR)) begin
				dvld_q <= '0;
				ptr_q  <= '0;
			end else if (push) begin
				dvld_q[ptr_q] <= 1'b1;
				ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
			end
		end
	end

	// multiply-accumulate on the shifted input history and the current output history
	always_comb begin
		logic signed [PROD_W-1:0] prod;
		logic signed [ACC_W-1:0]  acc_r;
		ih_new[0] = rd_vld_s1 ? rd_data_s1 : '0;
		for (int i = 1; i < NUM_B_TAPS; i++) begin
			ih_new[i] = ih_q[i-1];
		end
		acc = '0;
		for (int i = 0; i < NUM_B_TAPS; i++) begin
			prod = arx_pkg::coef_tap(b_coef_q, 2'(i)) * ih_new[i];
			acc  = acc + ACC_W'(prod);
		end
		for (int i = 0; i < NUM_A_TAPS; i++) begin
			prod = arx_pkg::coef_tap(a_coef_q, 2'(i)) * oh_q[i];
			acc  = acc - ACC_W'(prod);
		end
		// round half up to q8.8
		acc_r = acc + RND_HALF;
		y_rnd = RND_W'(acc_r >>> arx_pkg::FRAC_SHIFT);
		if (y_rnd > Y_MAX) begin
			y_sat = arx_pkg::Q88_MAX;
		end else if (y_rnd < Y_MIN) begin
			y_sat = arx_pkg::Q88_MIN;
		end else begin
			y_sat = y_rnd[DW-1:0];
		end
		y_out = clamp_en_q[1] ? arx_pkg::clamp_pair(y_sat, out_min_q, out_max_q) : y_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_B_TAPS; i++) begin
				ih_q[i] <= '0;
			end
			for (int i = 0; i < NUM_A_TAPS; i++) begin
				oh_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (adv2) begin
				case (op_s1)
					arx_pkg::OP_CLEAR: begin
						for (int i = 0; i < NUM_B_TAPS; i++) begin
							ih_q[i] <= '0;
						end
						for (int i = 0; i < NUM_A_TAPS; i++) begin
							oh_q[i] <= '0;
						end
					end
					arx_pkg::OP_SIMULATE, arx_pkg::OP_LOAD: begin
						for (int i = 0; i < NUM_B_TAPS; i++) begin
							ih_q[i] <= ih_new[i];
						end
						for (int i = 1; i < NUM_A_TAPS; i++) begin
							oh_q[i] <= oh_q[i-1];
						end
						oh_q[0] <= (op_s1 == arx_pkg::OP_SIMULATE) ? y_out : ym_s1;
					end
					default: ;
				endcase
			end
			if (adv2 && (op_s1 == arx_pkg::OP_SIMULATE)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && (op_s1 == arx_pkg::OP_SIMULATE)) begin
			model_output_q <= y_out;
		end
	end

	assign out_valid    = out_valid_q;
	assign model_output = model_output_q;

	// a stall on the input only comes from a held stage 1 item
	ast_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && (op_s1 == arx_pkg::OP_SIMULATE) && out_valid_q))
		else $error("input stall without a blocked simulate item");

	// a clear transfer empties every delay line entry and rewinds the pointer
	ast_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_op == arx_pkg::OP_CLEAR)) |=> ((dvld_q == '0) && (ptr_q == '0)))
		else $error("clear did not reset the delay line");

	ast_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q <= PTR_LAST))
		else $error("delay pointer out of range");

	// each simulate leaving stage 1 shows up as a result
	ast_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && (op_s1 == arx_pkg::OP_SIMULATE)) |=> out_valid_q)
		else $error("simulate item lost its result");

	// a pending result is never overwritten while stalled
	ast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(model_output_q)))
		else $error("stalled result changed");

endmodule

// ===== dv/arx_model_step_tb.sv =====
// testbench for arx_model_step: plant predictor, queue-fed driver, output monitor
`timescale 1ns / 100ps

module arx_model_step_tb;

	localparam int DELAY_SLOTS = arx_pkg::MAX_DELAY_DEF;
	localparam int PIPE_SETTLE = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 150;

	typedef logic signed [arx_pkg::DATA_W-1:0] sample_t;

	typedef struct {
		arx_pkg::op_t kind;
		sample_t      ctl;
		sample_t      meas;
	} plant_item_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [arx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [arx_pkg::PACK_W-1:0]    cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [1:0]                    op = arx_pkg::OP_NONE;
	sample_t                       control_sample = '0;
	sample_t                       measured_output = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	sample_t                       model_output;

	arx_model_step dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.control_sample  (control_sample),
		.measured_output (measured_output),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.model_output    (model_output)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor copy of the configuration
	logic [arx_pkg::PACK_W-1:0] a_pack = '0;
	logic [arx_pkg::PACK_W-1:0] b_pack = '0;
	sample_t                    ctl_lo = arx_pkg::LIMIT_LO;
	sample_t                    ctl_hi = arx_pkg::LIMIT_HI;
	sample_t                    out_lo = arx_pkg::LIMIT_LO;
	sample_t                    out_hi = arx_pkg::LIMIT_HI;
	logic [arx_pkg::DLEN_W-1:0] delay_len = 7'd1;
	logic [1:0]                 clamp_en = 2'b00;

	// predictor copy of the plant state, index 0 newest
	sample_t    u_hist [arx_pkg::NUM_B_TAPS_DEF] = '{default: '0};
	sample_t    y_hist [arx_pkg::NUM_A_TAPS_DEF] = '{default: '0};
	sample_t    dline [DELAY_SLOTS] = '{default: '0};
	logic [5:0] dptr = '0;

	plant_item_t plant_items [$];
	sample_t     expected_outputs [$];
	int          issued_count = 0;
	int          taken_count = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	bit          send_idle = 1'b0;
	bit          recv_idle = 1'b0;
	bit          item_taken = 1'b0;
	bit          result_taken = 1'b0;
	plant_item_t next_item;

	function automatic int bound_limit(input sample_t v);
		int r;
		r = v;
		if (r < arx_pkg::LIMIT_LO) r = arx_pkg::LIMIT_LO;
		if (r > arx_pkg::LIMIT_HI) r = arx_pkg::LIMIT_HI;
		return r;
	endfunction

	function automatic sample_t clip_to_limits(input sample_t v, input sample_t lo_raw,
			input sample_t hi_raw);
		int lo, hi, t;
		lo = bound_limit(lo_raw);
		hi = bound_limit(hi_raw);
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		if (v < lo) return sample_t'(lo);
		if (v > hi) return sample_t'(hi);
		return v;
	endfunction

	// advances the plant state by one item; returns 1 when a model output comes out
	function automatic bit plant_step(input arx_pkg::op_t kind, input sample_t u_in,
			input sample_t ym_in, output sample_t y_out);
		int      len, rd;
		longint  acc, y;
		sample_t u, ym, delayed, tap;
		y_out = '0;
		if (kind == arx_pkg::OP_CLEAR) begin
			u_hist = '{default: '0};
			y_hist = '{default: '0};
			dline = '{default: '0};
			dptr = '0;
			return 1'b0;
		end
		if (kind == arx_pkg::OP_NONE) return 1'b0;

		u = u_in;
		if (clamp_en[0]) u = clip_to_limits(u, ctl_lo, ctl_hi);
		len = delay_len;
		if (len < 1) len = 1;
		if (len > DELAY_SLOTS) len = DELAY_SLOTS;
		rd = (int'(dptr) + DELAY_SLOTS - len) % DELAY_SLOTS;
		delayed = dline[rd];
		dline[dptr] = u;
		dptr = dptr + 6'd1;
		for (int i = arx_pkg::NUM_B_TAPS_DEF - 1; i > 0; i--) u_hist[i] = u_hist[i-1];
		u_hist[0] = delayed;

		if (kind == arx_pkg::OP_LOAD) begin
			ym = ym_in;
			if (clamp_en[1]) ym = clip_to_limits(ym, out_lo, out_hi);
			for (int i = arx_pkg::NUM_A_TAPS_DEF - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
			y_hist[0] = ym;
			return 1'b0;
		end

		acc = 0;
		for (int i = 0; i < arx_pkg::NUM_B_TAPS_DEF; i++) begin
			tap = b_pack[16*i +: 16];
			acc += longint'(tap) * longint'(u_hist[i]);
		end
		for (int i = 0; i < arx_pkg::NUM_A_TAPS_DEF; i++) begin
			tap = a_pack[16*i +: 16];
			acc -= longint'(tap) * longint'(y_hist[i]);
		end
		// round half up to q8.8, then saturate
		y = (acc + 2048) >>> arx_pkg::FRAC_SHIFT;
		if (y > 32767) y = 32767;
		if (y < -32768) y = -32768;
		y_out = sample_t'(y);
		if (clamp_en[1]) y_out = clip_to_limits(y_out, out_lo, out_hi);
		for (int i = arx_pkg::NUM_A_TAPS_DEF - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
		y_hist[0] = y_out;
		return 1'b1;
	endfunction

	function automatic int draw_wait(input bit on);
		return on ? int'($urandom_range(0, 8)) : 0;
	endfunction

	// driver: payload changes on the falling edge, held until the transfer
	always @(negedge clk) begin
		if (!arst_n || (in_valid && !item_taken)) begin
			// current item still waiting for its transfer
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (plant_items.size() > 0) begin
			next_item = plant_items[0];
			plant_items.delete(0);
			in_valid <= 1'b1;
			op <= next_item.kind;
			control_sample <= next_item.ctl;
			measured_output <= next_item.meas;
			gap_left <= draw_wait(send_idle);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: a fresh stall count after every result transfer
	always @(negedge clk) begin : receiver
		int n;
		n = result_taken ? draw_wait(recv_idle) : stall_left;
		out_stall <= (n > 0);
		stall_left <= (n > 0) ? n - 1 : 0;
	end

	always @(posedge clk) begin : monitor
		bit      xfer_in, xfer_out;
		sample_t want, y;
		xfer_in = arst_n && (in_valid === 1'b1) && (in_stall === 1'b0);
		xfer_out = arst_n && (out_valid === 1'b1) && (out_stall === 1'b0);
		item_taken <= xfer_in;
		result_taken <= xfer_out;
		if (xfer_out) begin
			if (expected_outputs.size() == 0) begin
				$error("model_output: no transfer expected, actual %0d", model_output);
				mismatches++;
			end else begin
				want = expected_outputs[0];
				expected_outputs.delete(0);
				if (model_output !== want) begin
					$error("model_output: expected %0d, actual %0d", want, model_output);
					mismatches++;
				end
			end
		end
		if (xfer_in) begin
			if (plant_step(arx_pkg::op_t'(op), control_sample, measured_output, y))
				expected_outputs.insert(expected_outputs.size(), y);
			taken_count++;
		end
		if (xfer_in || xfer_out || cfg_we || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL arx_model_step");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic program_register(input arx_pkg::cfg_idx_t idx,
			input logic [arx_pkg::PACK_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			arx_pkg::CFG_A_COEF:    a_pack = val;
			arx_pkg::CFG_B_COEF:    b_pack = val;
			arx_pkg::CFG_CTRL_MIN:  ctl_lo = val[15:0];
			arx_pkg::CFG_CTRL_MAX:  ctl_hi = val[15:0];
			arx_pkg::CFG_OUT_MIN:   out_lo = val[15:0];
			arx_pkg::CFG_OUT_MAX:   out_hi = val[15:0];
			arx_pkg::CFG_DELAY_LEN: delay_len = val[arx_pkg::DLEN_W-1:0];
			arx_pkg::CFG_CLAMP_EN:  clamp_en = val[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_all(input logic [arx_pkg::PACK_W-1:0] a_val,
			input logic [arx_pkg::PACK_W-1:0] b_val,
			input sample_t c_lo, input sample_t c_hi, input sample_t o_lo, input sample_t o_hi,
			input logic [arx_pkg::DLEN_W-1:0] len, input logic [1:0] en);
		program_register(arx_pkg::CFG_A_COEF, a_val);
		program_register(arx_pkg::CFG_B_COEF, b_val);
		program_register(arx_pkg::CFG_CTRL_MIN, {32'd0, c_lo});
		program_register(arx_pkg::CFG_CTRL_MAX, {32'd0, c_hi});
		program_register(arx_pkg::CFG_OUT_MIN, {32'd0, o_lo});
		program_register(arx_pkg::CFG_OUT_MAX, {32'd0, o_hi});
		program_register(arx_pkg::CFG_DELAY_LEN, arx_pkg::PACK_W'(len));
		program_register(arx_pkg::CFG_CLAMP_EN, arx_pkg::PACK_W'(en));
	endtask

	task automatic queue_item(input arx_pkg::op_t kind, input sample_t ctl, input sample_t meas);
		plant_item_t it;
		it = '{kind: kind, ctl: ctl, meas: meas};
		plant_items.insert(plant_items.size(), it);
		issued_count++;
	endtask

	// wait for every transfer and result, then let load or clear items settle
	task automatic drain_plant();
		do @(negedge clk);
		while (plant_items.size() != 0 || taken_count != issued_count
			|| expected_outputs.size() != 0);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	function automatic logic [arx_pkg::PACK_W-1:0] random_taps(input int span);
		logic [arx_pkg::PACK_W-1:0] r;
		int mode;
		mode = $urandom_range(0, 4);
		if (mode == 0) begin
			r = arx_pkg::PACK_W'({$urandom, $urandom});
		end else if (mode == 1) begin
			r = '0;
		end else begin
			for (int i = 0; i < 3; i++)
				r[16*i +: 16] = 16'($urandom_range(0, 2 * span) - span);
		end
		return r;
	endfunction

	function automatic sample_t random_limit();
		if ($urandom_range(0, 3) == 0) return sample_t'($urandom);
		return sample_t'(int'($urandom_range(0, 51200)) - 25600);
	endfunction

	function automatic sample_t random_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return sample_t'($urandom);
		if (r < 8) return sample_t'(int'($urandom_range(0, 4096)) - 2048);
		if (r == 8) return $urandom_range(0, 1) ? arx_pkg::Q88_MAX : arx_pkg::Q88_MIN;
		return '0;
	endfunction

	function automatic arx_pkg::op_t random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72) return arx_pkg::OP_SIMULATE;
		if (r < 90) return arx_pkg::OP_LOAD;
		if (r < 94) return arx_pkg::OP_CLEAR;
		return arx_pkg::OP_NONE;
	endfunction

	initial begin
		logic [arx_pkg::DLEN_W-1:0] len;
		logic [1:0]                 en;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// clamping on with swapped control limits and out-of-range output limits
		program_all({16'sd512, -16'sd1024, 16'sd2048}, {-16'sd1024, 16'sd2048, 16'sd4096},
			16'sd5000, -16'sd3000, arx_pkg::Q88_MIN, arx_pkg::Q88_MAX, 7'd2, 2'b11);
		@(posedge clk);
		queue_item(arx_pkg::OP_CLEAR, '0, '0);
		queue_item(arx_pkg::OP_LOAD, arx_pkg::Q88_MAX, arx_pkg::Q88_MIN);
		queue_item(arx_pkg::OP_LOAD, arx_pkg::Q88_MIN, arx_pkg::Q88_MAX);
		queue_item(arx_pkg::OP_SIMULATE, '0, '0);
		queue_item(arx_pkg::OP_SIMULATE, arx_pkg::Q88_MAX, '0);
		queue_item(arx_pkg::OP_SIMULATE, arx_pkg::Q88_MIN, '0);
		queue_item(arx_pkg::OP_SIMULATE, 16'sd1000, '0);
		queue_item(arx_pkg::OP_NONE, 16'sh5555, 16'shaaaa);
		queue_item(arx_pkg::OP_SIMULATE, -16'sd1, 16'sh7fff);
		queue_item(arx_pkg::OP_CLEAR, 16'shffff, 16'shffff);
		queue_item(arx_pkg::OP_SIMULATE, 16'sd4000, '0);
		queue_item(arx_pkg::OP_SIMULATE, '0, '0);
		drain_plant();

		// clamping off, huge gains to hit both saturation rails, zero delay length
		send_idle = 1'b1;
		recv_idle = 1'b1;
		program_all({3{16'sh8000}}, {3{16'sh7fff}}, arx_pkg::LIMIT_LO, arx_pkg::LIMIT_HI,
			arx_pkg::LIMIT_LO, arx_pkg::LIMIT_HI, 7'd0, 2'b00);
		@(posedge clk);
		queue_item(arx_pkg::OP_LOAD, arx_pkg::Q88_MAX, arx_pkg::Q88_MAX);
		queue_item(arx_pkg::OP_LOAD, arx_pkg::Q88_MAX, arx_pkg::Q88_MAX);
		queue_item(arx_pkg::OP_SIMULATE, arx_pkg::Q88_MAX, '0);
		queue_item(arx_pkg::OP_SIMULATE, arx_pkg::Q88_MIN, '0);
		queue_item(arx_pkg::OP_SIMULATE, arx_pkg::Q88_MIN, '0);
		queue_item(arx_pkg::OP_SIMULATE, '0, '0);
		queue_item(arx_pkg::OP_NONE, arx_pkg::Q88_MAX, arx_pkg::Q88_MIN);
		queue_item(arx_pkg::OP_CLEAR, '0, '0);
		queue_item(arx_pkg::OP_SIMULATE, 16'sd256, '0);
		queue_item(arx_pkg::OP_SIMULATE, '0, '0);
		drain_plant();

		// random phases; plant state carries over, so delay changes hit a live line
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: len = 7'd64;
				1: len = 7'd127;
				2: len = 7'd1;
				3: len = 7'd0;
				default: len = ($urandom_range(0, 4) == 0)
					? arx_pkg::DLEN_W'($urandom_range(0, 127))
					: arx_pkg::DLEN_W'($urandom_range(1, 64));
			endcase
			en = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
			send_idle = (p % 3 != 0) && ($urandom_range(0, 3) != 0);
			recv_idle = (p % 3 != 1) && ($urandom_range(0, 3) != 0);
			program_all(random_taps(1024), random_taps(4096), random_limit(), random_limit(),
				random_limit(), random_limit(), len, en);
			@(posedge clk);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				queue_item(random_op(), random_sample(), random_sample());
			drain_plant();
		end

		if (mismatches == 0)
			$display("PASS arx_model_step");
		else
			$display("FAIL arx_model_step");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/arx_pkg.sv
sv/arx_model_step.sv
dv/arx_model_step_tb.sv
